### hw/rtl/tbm_pkg.sv
// Shared types and constants of the BM25 / TF-IDF term score block.
package tbm_pkg;

  // Field widths of one input transaction and of the configuration port.
  localparam int unsigned TC_W      = 24;
  localparam int unsigned DF_W      = 32;
  localparam int unsigned DL_W      = 24;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Fixed-point format: internal values are Q30, the score is Q10.16.
  localparam int unsigned Q_FRAC          = 30;
  localparam int unsigned SCORE_FRAC_BITS = 16;
  localparam int unsigned SCORE_W         = 10 + SCORE_FRAC_BITS;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Natural log of two in Q28.
  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DOCS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TOKENS = 2'd2;

  // Score mode codes.
  localparam logic MODE_TFIDF = 1'b0;
  localparam logic MODE_BM25  = 1'b1;

  typedef struct packed {
    logic [TC_W-1:0] term_count;
    logic [DF_W-1:0] term_doc_frequency;
    logic [DL_W-1:0] doc_length;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               invalid;
  } out_item_t;

endpackage

### hw/rtl/tbm_log_pipe.sv
// Pipelined natural logarithm in Q30 over several lanes, one squaring per stage.
module tbm_log_pipe
  import tbm_pkg::*;
#(
  parameter int unsigned LANES = 3,
  parameter int unsigned XW    = 34,
  parameter int unsigned SW    = 1,
  localparam int unsigned LW   = $clog2(XW) + Q_FRAC
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][XW-1:0]   x_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][LW-1:0]   ln_o,
  output logic [SW-1:0]              side_o
);

  localparam int unsigned PW  = $clog2(XW);
  localparam int unsigned NSQ = Q_FRAC;
  localparam int unsigned HW  = LW - 18;

  // Index of the highest set bit; zero for a zero input.
  function automatic logic [PW-1:0] top_bit(input logic [XW-1:0] x);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        r = PW'(i);
      end
    end
    return r;
  endfunction

  logic                      va_q, vb_q, vd_q, ve_q;
  logic [NSQ:0]              vs_q;
  logic [LANES-1:0][XW-1:0]  xa_q, xb_q;
  logic [LANES-1:0][PW-1:0]  pb_q, pb_d;
  logic [SW-1:0]             sa_q, sb_q, sd_q, se_q;
  logic [SW-1:0]             ss_q [NSQ+1];
  logic [LANES-1:0][30:0]    m_q  [NSQ+1];
  logic [LANES-1:0][30:0]    m_d  [NSQ+1];
  logic [LANES-1:0][29:0]    fr_q [NSQ+1];
  logic [LANES-1:0][29:0]    fr_d [NSQ+1];
  logic [LANES-1:0][PW-1:0]  p_q  [NSQ+1];
  logic [LANES-1:0][HW+27:0] ph_q, ph_d;
  logic [LANES-1:0][45:0]    pl_q, pl_d;
  logic [LANES-1:0][LW-1:0]  ln_q, ln_d;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [XW+30:0] sh;
    logic [LW-1:0]  lv;
    logic [LW+28:0] lsum;

    // Leading-one detect, then normalize the mantissa to [1,2).
    assign pb_d[l] = top_bit(xa_q[l]);

    always_comb begin
      if (pb_q[l] <= PW'(30)) begin
        sh = (XW+31)'(xb_q[l]) << (PW'(30) - pb_q[l]);
      end else begin
        sh = (XW+31)'(xb_q[l]) >> (pb_q[l] - PW'(30));
      end
    end

    assign m_d[0][l]  = sh[30:0];
    assign fr_d[0][l] = '0;

    // One fraction bit per stage: square the mantissa, renormalize.
    for (genvar k = 1; k <= NSQ; k++) begin : g_sq
      logic [61:0] sq;
      assign sq = 62'(m_q[k-1][l]) * 62'(m_q[k-1][l]);
      assign m_d[k][l]  = sq[61] ? sq[61:31] : sq[60:30];
      assign fr_d[k][l] = {fr_q[k-1][l][28:0], sq[61]};
    end

    // Scale log2 by ln(2) in two partial products.
    assign lv       = {p_q[NSQ][l], fr_q[NSQ][l]};
    assign ph_d[l]  = (HW+28)'(lv[LW-1:18]) * (HW+28)'(LN2_Q28);
    assign pl_d[l]  = 46'(lv[17:0]) * 46'(LN2_Q28);
    assign lsum     = ((LW+29)'(ph_q[l]) << 18) + (LW+29)'(pl_q[l]);
    assign ln_d[l]  = lsum[LW+27:28];
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vs_q <= '0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vs_q <= {vs_q[NSQ-1:0], vb_q};
      vd_q <= vs_q[NSQ];
      ve_q <= vd_q;
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q     <= x_i;
      sa_q     <= side_i;
      xb_q     <= xa_q;
      pb_q     <= pb_d;
      sb_q     <= sa_q;
      m_q[0]   <= m_d[0];
      fr_q[0]  <= fr_d[0];
      p_q[0]   <= pb_q;
      ss_q[0]  <= sb_q;
      for (int k = 1; k <= NSQ; k++) begin
        m_q[k]  <= m_d[k];
        fr_q[k] <= fr_d[k];
        p_q[k]  <= p_q[k-1];
        ss_q[k] <= ss_q[k-1];
      end
      ph_q <= ph_d;
      pl_q <= pl_d;
      sd_q <= ss_q[NSQ];
      ln_q <= ln_d;
      se_q <= sd_q;
    end
  end

  assign valid_o = ve_q;
  assign ln_o    = ln_q;
  assign side_o  = se_q;

endmodule

### hw/rtl/tbm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module tbm_div_pipe
  import tbm_pkg::*;
#(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  // The quotient must fit in QW bits, so the remainder of stage k stays
  // below the divisor shifted by the bit position of that stage.
  localparam int unsigned RW = DW + QW;

  logic [QW:0]   v_q;
  logic [RW-1:0] rem_q [QW+1];
  logic [RW-1:0] rem_d [QW+1];
  logic [DW-1:0] dv_q  [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [QW-1:0] quo_d [QW+1];
  logic [SW-1:0] sd_q  [QW+1];

  assign rem_d[0] = RW'(dividend_i);
  assign quo_d[0] = '0;

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int unsigned I = QW - k;
    logic [DW:0]   hi;
    logic          ge;
    logic [RW-1:0] r_n;

    // Trial subtract of the divisor at bit position I.
    assign hi = rem_q[k-1][I +: DW+1];
    assign ge = hi >= {1'b0, dv_q[k-1]};

    always_comb begin
      r_n = rem_q[k-1];
      if (ge) begin
        r_n[I +: DW+1] = hi - {1'b0, dv_q[k-1]};
      end
    end

    assign rem_d[k] = r_n;
    assign quo_d[k] = {quo_q[k-1][QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      dv_q[0]  <= divisor_i;
      quo_q[0] <= quo_d[0];
      sd_q[0]  <= side_i;
      for (int k = 1; k <= QW; k++) begin
        rem_q[k] <= rem_d[k];
        dv_q[k]  <= dv_q[k-1];
        quo_q[k] <= quo_d[k];
        sd_q[k]  <= sd_q[k-1];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = quo_q[QW];
  assign side_o  = sd_q[QW];

endmodule

### hw/rtl/tfidf_bm25_term_score.sv
// Top level of the BM25 / TF-IDF term score pipeline.
//
// Scores one query term against one document per input transaction.
// Input channel: in_valid_i / in_stall_o with in_data_i (term count,
// document frequency, document length). Output channel: out_valid_o /
// out_stall_i with out_data_o (Q10.16 score and invalid flag).
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 score mode, 1 total documents, 2 total tokens); write only while
// no transaction is in flight.
// Stages in order: a 35-stage log unit, dividers for the average length
// and the length ratio, a three-stage reciprocal multiply for the BM25
// length factor, a divider for the saturation ratio, then two stages of
// multiply and scaling. One transaction enters every cycle while the
// output is not stalled.
// The whole pipeline advances together; when the output register holds
// a result and out_stall_i is high, every stage holds and in_stall_o rises.
// Reset empties the pipeline and sets BM25 mode with zero counts.
module tfidf_bm25_term_score
  import tbm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  localparam int unsigned CNT_W      = (COUNT_WIDTH < DF_W) ? COUNT_WIDTH : DF_W;
  localparam int unsigned LOG_XW     = (CNT_W + 2 > TC_W + 1) ? CNT_W + 2 : TC_W + 1;
  localparam int unsigned LNW        = $clog2(LOG_XW) + Q_FRAC;
  localparam int unsigned IDW        = LNW + 2;
  localparam int unsigned IW         = LNW + 1;
  localparam int unsigned QN_W       = DL_W + Q_FRAC;
  localparam int unsigned KN_W       = QN_W + 4;
  localparam int unsigned K_W        = QN_W + 1;
  localparam int unsigned RATIO_FRAC = 28;
  localparam int unsigned R_W        = RATIO_FRAC + 1;
  localparam int unsigned RN_W       = LNW + RATIO_FRAC;
  localparam int unsigned RD_W       = ((LNW > K_W) ? LNW : K_W) + 1;
  localparam int unsigned SUMW       = IW + 30;

  typedef struct packed {
    logic            tc_zero;
    logic            df_zero;
    logic [DL_W-1:0] dl;
  } lg_side_t;

  typedef struct packed {
    logic            tc_zero;
    logic            df_zero;
    logic [DL_W-1:0] dl;
    logic [LNW-1:0]  tf;
    logic [IDW-1:0]  idf;
  } ad_side_t;

  typedef struct packed {
    logic           tc_zero;
    logic           df_zero;
    logic           adl_zero;
    logic [LNW-1:0] tf;
    logic [IDW-1:0] idf;
  } sc_side_t;

  // Configuration registers.
  logic             mode_q;
  logic [CNT_W-1:0] n_q, tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BM25;
      n_q    <= '0;
      tok_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCORE_MODE:   mode_q <= cfg_wdata_i[0];
        CFG_TOTAL_DOCS:   n_q    <= cfg_wdata_i[CNT_W-1:0];
        CFG_TOTAL_TOKENS: tok_q  <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // All stages advance together unless a held result is stalled.
  logic en;
  logic out_valid_q;
  out_item_t out_data_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Log arguments: tc+1, the document frequency term and the collection term.
  logic [2:0][LOG_XW-1:0] x_in;
  logic [CNT_W-1:0]       df_in;
  lg_side_t               lg_in, lg_out;
  logic                   lg_v;
  logic [2:0][LNW-1:0]    lg_ln;

  assign df_in   = in_data_i.term_doc_frequency[CNT_W-1:0];
  assign x_in[0] = LOG_XW'(in_data_i.term_count) + LOG_XW'(1);
  assign x_in[1] = (mode_q == MODE_BM25) ? (LOG_XW'(df_in) << 1) + LOG_XW'(1)
                                         : LOG_XW'(df_in);
  assign x_in[2] = (mode_q == MODE_BM25) ? (LOG_XW'(n_q) << 1) + LOG_XW'(2)
                                         : LOG_XW'(n_q);

  assign lg_in.tc_zero = (in_data_i.term_count == '0);
  assign lg_in.df_zero = (df_in == '0);
  assign lg_in.dl      = in_data_i.doc_length;

  tbm_log_pipe #(
    .LANES (3),
    .XW    (LOG_XW),
    .SW    ($bits(lg_side_t))
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (x_in),
    .side_i  (lg_in),
    .valid_o (lg_v),
    .ln_o    (lg_ln),
    .side_o  (lg_out)
  );

  // IDF difference; TF-IDF adds one in Q30.
  ad_side_t ad_in, ad_out;
  logic     ad_v;
  logic [CNT_W-1:0] adl;

  assign ad_in.tc_zero = lg_out.tc_zero;
  assign ad_in.df_zero = lg_out.df_zero;
  assign ad_in.dl      = lg_out.dl;
  assign ad_in.tf      = lg_ln[0];
  assign ad_in.idf     = IDW'(lg_ln[2]) - IDW'(lg_ln[1])
                       + ((mode_q == MODE_BM25) ? IDW'(0) : (IDW'(1) << Q_FRAC));

  // Average document length.
  tbm_div_pipe #(
    .NW (CNT_W),
    .DW (CNT_W),
    .QW (CNT_W),
    .SW ($bits(ad_side_t))
  ) u_div_adl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (lg_v),
    .dividend_i (tok_q),
    .divisor_i  (n_q),
    .side_i     (ad_in),
    .valid_o    (ad_v),
    .quot_o     (adl),
    .side_o     (ad_out)
  );

  // Document length over average length, Q30.
  sc_side_t q_in, q_out, k_out, r_out;
  logic     q_v, k_v, r_v;
  logic [QN_W-1:0] q_quo;
  logic [K_W-1:0]  k_quo;
  logic [R_W-1:0]  r_quo;

  assign q_in.tc_zero  = ad_out.tc_zero;
  assign q_in.df_zero  = ad_out.df_zero;
  assign q_in.adl_zero = (adl == '0) || (n_q == '0);
  assign q_in.tf       = ad_out.tf;
  assign q_in.idf      = ad_out.idf;

  tbm_div_pipe #(
    .NW (QN_W),
    .DW (CNT_W),
    .QW (QN_W),
    .SW ($bits(sc_side_t))
  ) u_div_len (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (ad_v),
    .dividend_i ({ad_out.dl, {Q_FRAC{1'b0}}}),
    .divisor_i  (adl),
    .side_i     (q_in),
    .valid_o    (q_v),
    .quot_o     (q_quo),
    .side_o     (q_out)
  );

  // Length factor K = (3 + 9q) / 10 in Q30. Half the numerator is multiplied
  // by the reciprocal (2^58 + 1) / 5 and shifted down by 58, which is exact
  // for every numerator below 2^58. Four partial products, then two adds.
  localparam logic [27:0] K_RCP_HI = 28'hCCCCCCC;
  localparam logic [27:0] K_RCP_LO = 28'hCCCCCCD;

  logic [KN_W-1:0] k_num;
  logic [56:0]     k_y;
  logic            ka_v_q, kb_v_q, kc_v_q;
  sc_side_t        ka_s_q, kb_s_q, kc_s_q;
  logic [55:0]     ka_hh_q, ka_hl_q;
  logic [56:0]     ka_lh_q, ka_ll_q;
  logic [55:0]     kb_hh_q;
  logic [58:0]     kb_mid_q;
  logic [84:0]     k_sum;
  logic [K_W-1:0]  kc_quo_q;

  assign k_num = (KN_W'(q_quo) << 3) + KN_W'(q_quo) + (KN_W'(3) << Q_FRAC);
  assign k_y   = k_num[KN_W-1:1];
  assign k_sum = (85'(kb_hh_q) << 29) + 85'(kb_mid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ka_v_q <= 1'b0;
      kb_v_q <= 1'b0;
      kc_v_q <= 1'b0;
    end else if (en) begin
      ka_v_q <= q_v;
      kb_v_q <= ka_v_q;
      kc_v_q <= kb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ka_hh_q  <= 56'(k_y[56:29]) * 56'(K_RCP_HI);
      ka_hl_q  <= 56'(k_y[56:29]) * 56'(K_RCP_LO);
      ka_lh_q  <= 57'(k_y[28:0]) * 57'(K_RCP_HI);
      ka_ll_q  <= 57'(k_y[28:0]) * 57'(K_RCP_LO);
      ka_s_q   <= q_out;
      kb_hh_q  <= ka_hh_q;
      kb_mid_q <= (59'(ka_hl_q) << 1) + 59'(ka_lh_q) + 59'(ka_ll_q[56:28]);
      kb_s_q   <= ka_s_q;
      kc_quo_q <= k_sum[84:30];
      kc_s_q   <= kb_s_q;
    end
  end

  assign k_v   = kc_v_q;
  assign k_quo = kc_quo_q;
  assign k_out = kc_s_q;

  // Saturation ratio tf / (tf + K) in Q28.
  tbm_div_pipe #(
    .NW (RN_W),
    .DW (RD_W),
    .QW (R_W),
    .SW ($bits(sc_side_t))
  ) u_div_ratio (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (k_v),
    .dividend_i ({k_out.tf, {RATIO_FRAC{1'b0}}}),
    .divisor_i  (RD_W'(k_out.tf) + RD_W'(k_quo)),
    .side_i     (k_out),
    .valid_o    (r_v),
    .quot_o     (r_quo),
    .side_o     (r_out)
  );

  // Multiply stage: split products for both modes.
  logic [IW-1:0]         idf_mag;
  logic                  f1_v_q;
  logic                  f1_tc_zero_q, f1_df_zero_q, f1_adl_zero_q, f1_pos_q;
  logic [LNW+IW-16:0]    p1_q;
  logic [LNW+14:0]       p2_q;
  logic [R_W+IW-18:0]    r1_q;
  logic [R_W+16:0]       r2_q;

  assign idf_mag = r_out.idf[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= r_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_tc_zero_q  <= r_out.tc_zero;
      f1_df_zero_q  <= r_out.df_zero;
      f1_adl_zero_q <= r_out.adl_zero;
      f1_pos_q      <= !r_out.idf[IDW-1] && (r_out.idf != '0);
      p1_q <= (LNW+IW-15)'(r_out.tf) * (LNW+IW-15)'(idf_mag[IW-1:15]);
      p2_q <= (LNW+15)'(r_out.tf) * (LNW+15)'(idf_mag[14:0]);
      r1_q <= (R_W+IW-17)'(r_quo) * (R_W+IW-17)'(idf_mag[IW-1:17]);
      r2_q <= (R_W+17)'(r_quo) * (R_W+17)'(idf_mag[16:0]);
    end
  end

  // Final scaling, saturation and special cases.
  logic [SUMW-1:0]    s_t, s_b, s_sel, s_out;
  logic [SCORE_W-1:0] s_sat;
  out_item_t          res;

  assign s_t   = (SUMW'(p1_q) + (SUMW'(p2_q) >> 15)) >> 15;
  assign s_b   = ((SUMW'(r1_q) << 17) + SUMW'(r2_q)) >> RATIO_FRAC;
  assign s_sel = (mode_q == MODE_BM25) ? s_b : s_t;
  assign s_out = s_sel >> (Q_FRAC - SCORE_FRAC_BITS);
  assign s_sat = (s_out > SUMW'(SCORE_MAX)) ? SCORE_MAX : s_out[SCORE_W-1:0];

  always_comb begin
    res.invalid = f1_tc_zero_q || ((mode_q == MODE_BM25) && f1_adl_zero_q);
    if (res.invalid) begin
      res.score = '0;
    end else if ((mode_q == MODE_TFIDF) && f1_df_zero_q) begin
      res.score = SCORE_MAX;
    end else if ((mode_q == MODE_TFIDF) && (n_q == '0)) begin
      res.score = '0;
    end else if (!f1_pos_q) begin
      res.score = '0;
    end else begin
      res.score = s_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/tbm_checker.sv
// Port-level checker of the term score block and its bind statement.
module tbm_checker
  import tbm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  // An undefined score always reads as zero.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.invalid) |-> (out_data_i.score == '0))
    else $error("invalid result carries a nonzero score");

  // A held, stalled result blocks new transactions.
  a_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |-> in_stall_i)
    else $error("input taken while output is blocked");

  // With the output register empty the block always takes input.
  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> !in_stall_i)
    else $error("input stalled with an empty output register");

endmodule

bind tfidf_bm25_term_score tbm_checker u_tbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
